/* rtl/core/ffbra_pkg.sv */
// Shared types and constants for the first-fit block run allocator.
package ffbra_pkg;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [3:0] SHIFT_MAX = 4'd12;

   localparam int SIZE_W  = 21;
   localparam int OFF_W   = 20;
   localparam int BLK_W   = 8;
   localparam int USED_W  = 9;
   localparam int NEED_W  = SIZE_W + 1;

   // One finished response as it leaves the sequencer.
   typedef struct packed {
      logic [USED_W-1:0] blocks_in_use;
      logic              arena_empty;
      logic [OFF_W-1:0]  byte_offset;
      logic [BLK_W-1:0]  block_start;
      logic              ok;
   } ffbra_rsp_type;

endpackage

/* rtl/core/ffbra_map.sv */
// Run map memory with a clearing sweep after reset.
module ffbra_map
   import ffbra_pkg::*;
#(
   parameter int BLOCKS = 256,
   parameter int BW     = $clog2(BLOCKS),
   parameter int CW     = $clog2(BLOCKS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [BW-1:0] rd_addr,
   output logic [CW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [BW-1:0] wr_addr,
   input  logic [CW-1:0] wr_data,
   output logic          busy
);

   logic [CW-1:0] mem [BLOCKS];
   logic [CW-1:0] rd_data_ff;
   logic [BW-1:0] clr_addr_ff;
   logic [BW-1:0] clr_addr_in;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic          clr_last;

   assign clr_last = (32'(clr_addr_ff) == 32'(BLOCKS - 1));

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + BW'(1);
         if (clr_last) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

/* rtl/core/ffbra_seq.sv */
// Sequencer: request checks, first-fit scan with one shared index adder, free path.
module ffbra_seq
   import ffbra_pkg::*;
#(
   parameter int BLOCKS = 256,
   parameter int BW     = $clog2(BLOCKS),
   parameter int CW     = $clog2(BLOCKS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              kind,
   input  logic [SIZE_W-1:0] size_bytes,
   input  logic [OFF_W-1:0]  offset_bytes,
   input  logic [3:0]        shift,
   input  logic              out_free,
   output logic              idle,
   output logic [BW-1:0]     rd_addr,
   input  logic [CW-1:0]     rd_data,
   output logic              wr_en,
   output logic [BW-1:0]     wr_addr,
   output logic [CW-1:0]     wr_data,
   output logic              rsp_load,
   output ffbra_rsp_type     rsp
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_FREE  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              kind_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [CW-1:0]     need_ff, need_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     run_ff, run_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     res_used_ff, res_used_in;
   logic [BW-1:0]     res_blk_ff, res_blk_in;
   logic              res_ok_ff, res_ok_in;
   logic              res_empty_ff, res_empty_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [CW-1:0]     wr_data_ff, wr_data_in;

   logic [NEED_W-1:0] round_mask;
   logic [NEED_W-1:0] need_full;
   logic              alloc_bad;
   logic [OFF_W-1:0]  free_blk;
   logic              free_in_range;
   logic [CW:0]       step_sum;
   logic [CW:0]       run_inc;
   logic              scan_end;
   logic [31:0]       blk_wide;
   logic [31:0]       off_wide;
   logic [31:0]       used_wide;

   // request decode, done in the check cycle
   assign round_mask = (NEED_W'(1) << shift) - NEED_W'(1);
   assign need_full  = (NEED_W'(size_ff) + round_mask) >> shift;
   assign alloc_bad  = (need_full == '0) || (32'(need_full) > 32'(BLOCKS)) ||
                       (32'(need_full) > (32'(BLOCKS) - 32'(used_ff)));
   assign free_blk      = off_ff >> shift;
   assign free_in_range = (32'(free_blk) < 32'(BLOCKS));

   // shared scan adder: step one block over a free entry, jump over a live run
   assign step_sum = (CW + 1)'(idx_ff) + ((rd_data == '0) ? (CW + 1)'(1) : (CW + 1)'(rd_data));
   assign run_inc  = (CW + 1)'(run_ff) + (CW + 1)'(1);
   assign scan_end = (32'(step_sum) >= 32'(BLOCKS));

   always_comb begin
      state_in     = state_ff;
      need_in      = need_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      used_in      = used_ff;
      res_used_in  = res_used_ff;
      res_blk_in   = res_blk_ff;
      res_ok_in    = res_ok_ff;
      res_empty_in = res_empty_ff;
      wr_pend_in   = wr_pend_ff;
      wr_data_in   = wr_data_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_ok_in    = 1'b0;
            res_blk_in   = '0;
            res_empty_in = 1'b0;
            res_used_in  = used_ff;
            wr_pend_in   = 1'b0;
            if (kind_ff == KIND_ALLOC) begin
               need_in = CW'(need_full);
               idx_in  = '0;
               run_in  = '0;
               rd_addr = '0;
               state_in = alloc_bad ? ST_RESP : ST_SCAN;
            end else begin
               rd_addr    = free_blk[BW-1:0];
               res_blk_in = free_in_range ? free_blk[BW-1:0] : '0;
               state_in   = free_in_range ? ST_FREE : ST_RESP;
            end
         end
         ST_SCAN: begin
            rd_addr = step_sum[BW-1:0];
            if (rd_data == '0 && run_inc >= (CW + 1)'(need_ff)) begin
               res_ok_in   = 1'b1;
               res_blk_in  = BW'(idx_ff - run_ff);
               res_used_in = used_ff + need_ff;
               wr_pend_in  = 1'b1;
               wr_data_in  = need_ff;
               state_in    = ST_RESP;
            end else begin
               idx_in = CW'(step_sum);
               run_in = (rd_data == '0) ? CW'(run_inc) : '0;
               if (scan_end) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_FREE: begin
            if (rd_data == '0) begin
               res_blk_in = '0;
            end else begin
               res_ok_in  = 1'b1;
               wr_pend_in = 1'b1;
               wr_data_in = '0;
               if (used_ff <= rd_data) begin
                  res_used_in  = '0;
                  res_empty_in = 1'b1;
               end else begin
                  res_used_in = used_ff - rd_data;
               end
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               wr_en    = wr_pend_ff;
               used_in  = res_used_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         kind_ff <= kind;
         size_ff <= size_bytes;
         off_ff  <= offset_bytes;
      end
      need_ff      <= need_in;
      idx_ff       <= idx_in;
      run_ff       <= run_in;
      res_used_ff  <= res_used_in;
      res_blk_ff   <= res_blk_in;
      res_ok_ff    <= res_ok_in;
      res_empty_ff <= res_empty_in;
      wr_pend_ff   <= wr_pend_in;
      wr_data_ff   <= wr_data_in;
   end

   assign wr_addr = res_blk_ff;
   assign wr_data = wr_data_ff;
   assign idle    = (state_ff == ST_IDLE);

   assign blk_wide  = 32'(res_blk_ff);
   assign off_wide  = blk_wide << shift;
   assign used_wide = 32'(res_used_ff);

   assign rsp.ok            = res_ok_ff;
   assign rsp.block_start   = blk_wide[BLK_W-1:0];
   assign rsp.byte_offset   = off_wide[OFF_W-1:0];
   assign rsp.arena_empty   = res_empty_ff;
   assign rsp.blocks_in_use = used_wide[USED_W-1:0];

endmodule

/* rtl/core/first_fit_block_run_allocator.sv */
// First-fit block run allocator: an alloc passes the check state and, unless rejected, the
// scan state; a free passes the check state and, if in range, the free state; one request in flight.
// The scan reads one run map entry per cycle through the memory's registered port
// and jumps over live runs; a new request is accepted only once the last response is loaded.
// After reset the run map is zeroed entry by entry with req_tready low;
// block_shift resets to 4 and the used count to 0.
module first_fit_block_run_allocator
   import ffbra_pkg::*;
#(
   parameter int BLOCKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // size_bytes[20:0], offset_bytes[40:21]
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // ok[0], block_start[8:1], byte_offset[28:9],
                                   // arena_empty[29], blocks_in_use[38:30]
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CW = $clog2(BLOCKS + 1);

   logic [3:0]    block_shift_ff, block_shift_in;
   logic [3:0]    eff_shift;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff;
   logic          seq_idle;
   logic          map_busy;
   logic          out_free;
   logic          rsp_load;
   ffbra_rsp_type seq_rsp;
   logic [BW-1:0] rd_addr;
   logic [CW-1:0] rd_data;
   logic          wr_en;
   logic [BW-1:0] wr_addr;
   logic [CW-1:0] wr_data;

   assign block_shift_in = csr_wr_en ? csr_wr_data : block_shift_ff;
   assign eff_shift      = (block_shift_ff > SHIFT_MAX) ? SHIFT_MAX : block_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff <= 4'd4;
      end else begin
         block_shift_ff <= block_shift_in;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = seq_idle && !map_busy;

   ffbra_map #(
      .BLOCKS (BLOCKS),
      .BW     (BW),
      .CW     (CW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .busy    (map_busy)
   );

   ffbra_seq #(
      .BLOCKS (BLOCKS),
      .BW     (BW),
      .CW     (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_tvalid && req_tready),
      .kind         (req_tuser),
      .size_bytes   (req_tdata[20:0]),
      .offset_bytes (req_tdata[40:21]),
      .shift        (eff_shift),
      .out_free     (out_free),
      .idle         (seq_idle),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rsp_load     (rsp_load),
      .rsp          (seq_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, seq_rsp};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
